/* design/biased_varint_decoder_defines.svh */
// Assertion macros used by the file that checks this block.
// Every check is clocked on clk and switched off while rst is high.
`ifndef BIASED_VARINT_DECODER_DEFINES_SVH
`define BIASED_VARINT_DECODER_DEFINES_SVH

// Check that the condition holds in the same cycle as its trigger.
`define BVD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bvd same-cycle check failed");

// Check that the condition holds in the cycle after its trigger.
`define BVD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bvd next-cycle check failed");

`endif

/* design/bvd_pkg.sv */
`timescale 1ns / 1ps

package bvd_pkg;

  // Code forms: four biased lengths and the raw escape
  typedef enum logic [2:0] {
    FORM_SHORT  = 3'd0,
    FORM_ONE    = 3'd1,
    FORM_TWO    = 3'd2,
    FORM_THREE  = 3'd3,
    FORM_ESCAPE = 3'd4
  } form_t;

  localparam logic [7:0]  ESCAPE_BYTE = 8'hff;
  localparam logic [7:0]  HEADER_MASK = 8'hc0;

  localparam logic [31:0] BIAS_SHORT = 32'd16;
  localparam logic [31:0] BIAS_ONE   = 32'd4096;
  localparam logic [31:0] BIAS_TWO   = 32'd1048576;
  localparam logic [31:0] BIAS_THREE = 32'd134217728;

  typedef struct packed {
    logic [2:0]  bytes_left;
    form_t       code_form;
    logic [31:0] partial_value;
  } state_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         code_length;
  } result_t;

  // Bytes that follow the header
  function automatic logic [2:0] extra_of(input form_t form);
    logic [2:0] r;
    unique case (form)
      FORM_SHORT:  r = 3'd0;
      FORM_ONE:    r = 3'd1;
      FORM_TWO:    r = 3'd2;
      FORM_THREE:  r = 3'd3;
      FORM_ESCAPE: r = 3'd4;
      default:     r = 3'd4;
    endcase
    return r;
  endfunction

  // Bit position of the first byte after the header
  function automatic logic [4:0] shift_base_of(input form_t form);
    logic [4:0] r;
    unique case (form)
      FORM_ONE:   r = 5'd6;
      FORM_TWO:   r = 5'd6;
      FORM_THREE: r = 5'd5;
      default:    r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] bias_of(input form_t form);
    logic [31:0] r;
    unique case (form)
      FORM_SHORT: r = BIAS_SHORT;
      FORM_ONE:   r = BIAS_ONE;
      FORM_TWO:   r = BIAS_TWO;
      FORM_THREE: r = BIAS_THREE;
      default:    r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

/* design/biased_varint_decoder.sv */
`timescale 1ns / 1ps
`include "biased_varint_decoder_defines.svh"

// Decodes a byte stream of prefix-length, biased variable-length integers
// into signed 32-bit values, one byte per request and one byte per cycle
// sustained while m_tready holds. A header byte's top two bits pick a 1-
// to 4-byte code; 0xff starts a 5-byte escape carrying a raw little-endian
// 32-bit value. The byte that completes a code passes the input register and
// then the result register before its result (value and code length)
// leaves on the master side. The accumulator update sets the rate. Bytes
// that do not complete a code give no result. There is no
// resynchronisation: every byte seen while no code is open is a header.
module biased_varint_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [31:0] value, [34:32] code_length, [39:35] zero
);

  logic              in_valid;
  logic [7:0]        in_byte_q;
  logic              consume;
  logic              emit;
  bvd_pkg::result_t  dec_result;
  bvd_pkg::state_t   dec_state;
  bvd_pkg::result_t  out_result;

  // Consume the held byte whenever the result slot is free or draining
  assign consume  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || consume;

  // Hold the accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (consume) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte_q <= s_tdata;
    end
  end

  bvd_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .consume (consume),
    .in_byte (in_byte_q),
    .emit    (emit),
    .result  (dec_result),
    .state   (dec_state)
  );

  // Load the result register, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_result <= dec_result;
    end
  end

  assign m_tdata = {5'd0, out_result.code_length, out_result.value};

  `BVD_ASSERT_SAME(a_left_bound, 1'b1,
    dec_state.bytes_left <= bvd_pkg::extra_of(dec_state.code_form))
  `BVD_ASSERT_SAME(a_length_range, m_tvalid,
    out_result.code_length != 3'd0 && out_result.code_length <= 3'd5)
  `BVD_ASSERT_NEXT(a_escape_open,
    consume && dec_state.bytes_left == 3'd0 && in_byte_q == bvd_pkg::ESCAPE_BYTE,
    dec_state.code_form == bvd_pkg::FORM_ESCAPE && dec_state.bytes_left == 3'd4)
  `BVD_ASSERT_NEXT(a_emit_loads, emit, m_tvalid)

endmodule

/* design/bvd_decode.sv */
`timescale 1ns / 1ps

module bvd_decode (
  input  logic               clk,
  input  logic               rst,
  input  logic               consume,
  input  logic [7:0]         in_byte,
  output logic               emit,
  output bvd_pkg::result_t   result,
  output bvd_pkg::state_t    state
);

  bvd_pkg::state_t state_next;

  // Decode one byte against the current accumulator
  always_comb begin
    logic [2:0]      extra;
    logic [1:0]      k;
    logic [4:0]      sh;
    logic [31:0]     acc;
    logic [2:0]      left;
    bvd_pkg::form_t  form;
    extra = bvd_pkg::extra_of(state.code_form);
    form  = state.code_form;
    k     = 2'(extra - state.bytes_left);
    sh    = bvd_pkg::shift_base_of(state.code_form) + {k, 3'b000};
    if (state.bytes_left == 3'd0) begin
      if (in_byte == bvd_pkg::ESCAPE_BYTE) begin
        form = bvd_pkg::FORM_ESCAPE;
        acc  = 32'd0;
      end else if ((in_byte & bvd_pkg::HEADER_MASK) == bvd_pkg::HEADER_MASK) begin
        form = bvd_pkg::FORM_THREE;
        acc  = {27'd0, in_byte[4:0]};
      end else begin
        form = bvd_pkg::form_t'({1'b0, in_byte[7:6]});
        acc  = {26'd0, in_byte[5:0]};
      end
      left = bvd_pkg::extra_of(form);
    end else begin
      acc  = state.partial_value | ({24'd0, in_byte} << sh);
      left = state.bytes_left - 3'd1;
    end

    result.value       = $signed(acc - bvd_pkg::bias_of(form));
    result.code_length = bvd_pkg::extra_of(form) + 3'd1;
    emit               = consume && (left == 3'd0);

    // Return to header wait once a code completes
    if (left == 3'd0) begin
      state_next.bytes_left    = 3'd0;
      state_next.code_form     = bvd_pkg::FORM_SHORT;
      state_next.partial_value = 32'd0;
    end else begin
      state_next.bytes_left    = left;
      state_next.code_form     = form;
      state_next.partial_value = acc;
    end
  end

  // Advance the code state on each consumed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      state.bytes_left    <= 3'd0;
      state.code_form     <= bvd_pkg::FORM_SHORT;
      state.partial_value <= 32'd0;
    end else if (consume) begin
      state <= state_next;
    end
  end

endmodule
